### hw/rtl/osp_pkg.sv
package osp_pkg;

  localparam int SLOTS        = 64;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int CNT_W        = $clog2(SLOTS + 1);
  localparam int COORD_W      = 16;
  localparam int IDX_FIELD_W  = 6;
  localparam int LIVE_FIELD_W = 7;
  localparam int LIVE_MAX     = (1 << LIVE_FIELD_W) - 1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t vel_x;
    coord_t vel_y;
  } slot_rec_t;

  localparam int REC_W = $bits(slot_rec_t);

  typedef enum logic [1:0] {
    FN_CREATE = 2'd0,
    FN_DELETE = 2'd1,
    FN_TICK   = 2'd2,
    FN_NOP    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NOT_USED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_X_MIN = 2'd0,
    CFG_X_MAX = 2'd1,
    CFG_Y_MIN = 2'd2,
    CFG_Y_MAX = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DEL,
    ST_TICK_RD,
    ST_TICK_X,
    ST_TICK_Y,
    ST_FINISH
  } state_t;

  localparam coord_t X_MIN_RST = 16'sd0;
  localparam coord_t X_MAX_RST = 16'sd10240;
  localparam coord_t Y_MIN_RST = 16'sd0;
  localparam coord_t Y_MAX_RST = 16'sd7680;

  function automatic logic [SLOT_W-1:0] inc_slot(input logic [SLOT_W-1:0] s);
    if (s == SLOT_W'(SLOTS - 1)) begin
      return '0;
    end
    return s + SLOT_W'(1);
  endfunction

  function automatic logic [LIVE_FIELD_W-1:0] live_field(input logic [CNT_W-1:0] c);
    if (32'(c) > LIVE_MAX) begin
      return LIVE_FIELD_W'(LIVE_MAX);
    end
    return LIVE_FIELD_W'(c);
  endfunction

endpackage

### hw/rtl/osp_ifs.sv
interface osp_req_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         func;
  osp_pkg::coord_t                    pos_x;
  osp_pkg::coord_t                    pos_y;
  osp_pkg::coord_t                    vel_x;
  osp_pkg::coord_t                    vel_y;
  logic [osp_pkg::IDX_FIELD_W-1:0]    slot_index;

  modport source (output valid, func, pos_x, pos_y, vel_x, vel_y, slot_index,
                  input ready);
  modport sink (input valid, func, pos_x, pos_y, vel_x, vel_y, slot_index,
                output ready);
endinterface

interface osp_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic [osp_pkg::IDX_FIELD_W-1:0]    given_slot;
  logic [osp_pkg::LIVE_FIELD_W-1:0]   live_count;

  modport source (output valid, status, given_slot, live_count, input ready);
  modport sink (input valid, status, given_slot, live_count, output ready);
endinterface

### hw/rtl/osp_slot_ram.sv
module osp_slot_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/osp_axis_unit.sv
module osp_axis_unit (
  input  osp_pkg::coord_t pos,
  input  osp_pkg::coord_t vel,
  input  osp_pkg::coord_t lo,
  input  osp_pkg::coord_t hi,
  output osp_pkg::coord_t sum,
  output logic            in_box
);

  logic signed [osp_pkg::COORD_W:0] wide;

  always_comb begin
    wide = {pos[osp_pkg::COORD_W-1], pos} + {vel[osp_pkg::COORD_W-1], vel};
    if (wide[osp_pkg::COORD_W] != wide[osp_pkg::COORD_W-1]) begin
      sum = wide[osp_pkg::COORD_W] ? {1'b1, {(osp_pkg::COORD_W-1){1'b0}}}
                                   : {1'b0, {(osp_pkg::COORD_W-1){1'b1}}};
    end else begin
      sum = wide[osp_pkg::COORD_W-1:0];
    end
    in_box = (sum >= lo) && (sum <= hi);
  end

endmodule

### hw/rtl/object_slot_pool_with_motion.sv
// Create searches for a free slot from acceptance to a valid result: the free-slot
// search checks one valid bit per cycle. Delete and the unused selector need no search.
// Tick walks every slot in turn, with one slot-memory read and two passes
// through the shared saturating adder and box compare for each live slot.
// One word is in work at a time; the next is accepted once the result is registered.
// Synchronous reset clears all valid bits, the count and the seek pointer, and restores
// the default screen box.
module object_slot_pool_with_motion (
  input  logic                 clk,
  input  logic                 rst,
  osp_req_if.sink              req,
  osp_rsp_if.source            rsp,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  osp_pkg::state_t                 state, state_next;
  logic [osp_pkg::SLOTS-1:0]       valid, valid_next;
  logic [osp_pkg::CNT_W-1:0]       count, count_next;
  logic [osp_pkg::SLOT_W-1:0]      seek, seek_next;
  logic [osp_pkg::SLOT_W-1:0]      ptr, ptr_next;
  logic [osp_pkg::SLOT_W-1:0]      steps, steps_next;
  osp_pkg::status_t                status, status_next;
  logic [osp_pkg::SLOT_W-1:0]      given, given_next;
  osp_pkg::coord_t                 new_x, new_x_next;
  logic                            x_in, x_in_next;
  logic                            out_valid, out_valid_next;
  osp_pkg::status_t                out_status;
  logic [osp_pkg::IDX_FIELD_W-1:0] out_given;
  logic [osp_pkg::LIVE_FIELD_W-1:0] out_live;
  logic                            out_load;

  osp_pkg::coord_t                 x_min, x_max, y_min, y_max;
  osp_pkg::slot_rec_t              item_rec;
  logic [osp_pkg::IDX_FIELD_W-1:0] item_index;
  logic                            accept;

  logic                            ram_we;
  logic [osp_pkg::SLOT_W-1:0]      ram_waddr;
  osp_pkg::slot_rec_t              ram_wdata;
  logic [osp_pkg::REC_W-1:0]       ram_rdata;
  osp_pkg::slot_rec_t              rec;

  logic                            use_y;
  osp_pkg::coord_t                 unit_pos, unit_vel, unit_lo, unit_hi, unit_sum;
  logic                            unit_inside;

  logic [osp_pkg::SLOT_W-1:0]      del_idx;
  logic                            del_in_range;

  assign accept       = req.valid && req.ready;
  assign rec          = osp_pkg::slot_rec_t'(ram_rdata);
  assign del_idx      = osp_pkg::SLOT_W'(item_index);
  assign del_in_range = 32'(item_index) < osp_pkg::SLOTS;

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.given_slot = out_given;
  assign rsp.live_count = out_live;

  assign use_y    = (state == osp_pkg::ST_TICK_Y);
  assign unit_pos = use_y ? rec.pos_y : rec.pos_x;
  assign unit_vel = use_y ? rec.vel_y : rec.vel_x;
  assign unit_lo  = use_y ? y_min : x_min;
  assign unit_hi  = use_y ? y_max : x_max;

  osp_axis_unit u_axis (
    .pos    (unit_pos),
    .vel    (unit_vel),
    .lo     (unit_lo),
    .hi     (unit_hi),
    .sum    (unit_sum),
    .in_box (unit_inside)
  );

  osp_slot_ram #(
    .DEPTH (osp_pkg::SLOTS),
    .WIDTH (osp_pkg::REC_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min <= osp_pkg::X_MIN_RST;
      x_max <= osp_pkg::X_MAX_RST;
      y_min <= osp_pkg::Y_MIN_RST;
      y_max <= osp_pkg::Y_MAX_RST;
    end else if (cfg_we) begin
      unique case (osp_pkg::cfg_reg_t'(cfg_index))
        osp_pkg::CFG_X_MIN: x_min <= cfg_data;
        osp_pkg::CFG_X_MAX: x_max <= cfg_data;
        osp_pkg::CFG_Y_MIN: y_min <= cfg_data;
        osp_pkg::CFG_Y_MAX: y_max <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_rec.pos_x <= req.pos_x;
      item_rec.pos_y <= req.pos_y;
      item_rec.vel_x <= req.vel_x;
      item_rec.vel_y <= req.vel_y;
      item_index     <= req.slot_index;
    end
    if (out_load) begin
      out_status <= status;
      out_given  <= osp_pkg::IDX_FIELD_W'(given);
      out_live   <= osp_pkg::live_field(count);
    end
    status <= status_next;
    given  <= given_next;
    new_x  <= new_x_next;
    x_in   <= x_in_next;
    ptr    <= ptr_next;
    steps  <= steps_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= osp_pkg::ST_IDLE;
      valid     <= '0;
      count     <= '0;
      seek      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      valid     <= valid_next;
      count     <= count_next;
      seek      <= seek_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    valid_next     = valid;
    count_next     = count;
    seek_next      = seek;
    ptr_next       = ptr;
    steps_next     = steps;
    status_next    = status;
    given_next     = given;
    new_x_next     = new_x;
    x_in_next      = x_in;
    out_load       = 1'b0;
    out_valid_next = out_valid && !rsp.ready;
    ram_we         = 1'b0;
    ram_waddr      = use_y ? ptr : seek;
    ram_wdata      = use_y ? {new_x, unit_sum, rec.vel_x, rec.vel_y} : item_rec;
    req.ready      = (state == osp_pkg::ST_IDLE);

    unique case (state)
      osp_pkg::ST_IDLE: begin
        if (req.valid) begin
          status_next = osp_pkg::STAT_OK;
          given_next  = '0;
          steps_next  = '0;
          ptr_next    = '0;
          unique case (osp_pkg::func_t'(req.func))
            osp_pkg::FN_CREATE: state_next = osp_pkg::ST_SEARCH;
            osp_pkg::FN_DELETE: state_next = osp_pkg::ST_DEL;
            osp_pkg::FN_TICK:   state_next = osp_pkg::ST_TICK_RD;
            osp_pkg::FN_NOP:    state_next = osp_pkg::ST_FINISH;
          endcase
        end
      end
      osp_pkg::ST_SEARCH: begin
        if (!valid[seek]) begin
          ram_we           = 1'b1;
          valid_next[seek] = 1'b1;
          count_next       = count + osp_pkg::CNT_W'(1);
          given_next       = seek;
          state_next       = osp_pkg::ST_FINISH;
        end else begin
          seek_next = osp_pkg::inc_slot(seek);
          if (steps == osp_pkg::SLOT_W'(osp_pkg::SLOTS - 1)) begin
            status_next = osp_pkg::STAT_FULL;
            state_next  = osp_pkg::ST_FINISH;
          end else begin
            steps_next = steps + osp_pkg::SLOT_W'(1);
          end
        end
      end
      osp_pkg::ST_DEL: begin
        if (del_in_range && valid[del_idx]) begin
          valid_next[del_idx] = 1'b0;
          count_next          = count - osp_pkg::CNT_W'(1);
        end else begin
          status_next = osp_pkg::STAT_NOT_USED;
        end
        state_next = osp_pkg::ST_FINISH;
      end
      osp_pkg::ST_TICK_RD: begin
        if (valid[ptr]) begin
          state_next = osp_pkg::ST_TICK_X;
        end else if (ptr == osp_pkg::SLOT_W'(osp_pkg::SLOTS - 1)) begin
          state_next = osp_pkg::ST_FINISH;
        end else begin
          ptr_next = ptr + osp_pkg::SLOT_W'(1);
        end
      end
      osp_pkg::ST_TICK_X: begin
        new_x_next = unit_sum;
        x_in_next  = unit_inside;
        state_next = osp_pkg::ST_TICK_Y;
      end
      osp_pkg::ST_TICK_Y: begin
        ram_we = 1'b1;
        if (!(x_in && unit_inside)) begin
          valid_next[ptr] = 1'b0;
          count_next      = count - osp_pkg::CNT_W'(1);
        end
        if (ptr == osp_pkg::SLOT_W'(osp_pkg::SLOTS - 1)) begin
          state_next = osp_pkg::ST_FINISH;
        end else begin
          ptr_next   = ptr + osp_pkg::SLOT_W'(1);
          state_next = osp_pkg::ST_TICK_RD;
        end
      end
      osp_pkg::ST_FINISH: begin
        if (!out_valid || rsp.ready) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = osp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = osp_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    count == osp_pkg::CNT_W'($countones(valid)))
    else $error("live count differs from the number of valid slots");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("input accepted again while a word is in work");

  a_create_marks_slot: assert property (@(posedge clk) disable iff (rst)
    (state == osp_pkg::ST_SEARCH) && !valid[seek] |=> valid[$past(seek)])
    else $error("created slot not marked valid");

  a_full_only_when_all_busy: assert property (@(posedge clk) disable iff (rst)
    (state == osp_pkg::ST_FINISH) && (status == osp_pkg::STAT_FULL)
      |-> (32'(count) == osp_pkg::SLOTS))
    else $error("pool reported full with a free slot");
`endif

endmodule
